### hdl/atav_pkg.sv
package atav_pkg;

    // Sample and window geometry.
    localparam int SAMPLE_W   = 16;
    localparam int LIMIT_W    = 15;
    localparam int SUM_W      = 22;
    localparam int COUNT_W    = 6;
    localparam int WINDOW_DEF = 10;
    localparam logic [LIMIT_W-1:0] SHOCK_RESET = 15'd1000;

    // CORDIC datapath: sums scaled by 256 plus gain headroom.
    localparam int CORDIC_STEPS = 18;
    localparam int ITER_W       = 5;
    localparam int CDATA_W      = 34;
    localparam int ANGLE_W      = 22;
    localparam int OP_SHIFT     = 8;

    // Magnitude and square root widths.
    localparam int MAG_W  = 21;
    localparam int SQ_W   = 44;
    localparam int RAD_W  = 60;
    localparam int ROOT_W = 30;

    // Angles in 1/4096 degree and results in 1/64 degree.
    localparam logic signed [ANGLE_W-1:0] DEG180 = 22'sd737280;
    localparam logic signed [ANGLE_W-1:0] DEG360 = 22'sd1474560;
    localparam logic [14:0] ROLL_MAX   = 15'd23040;
    localparam logic [14:0] ROLL_HALF  = 15'd11520;
    localparam logic [13:0] PITCH_MAX  = 14'd5760;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RINIT,
        S_ROLL,
        S_MULY,
        S_MULZ,
        S_SQST,
        S_SQRT,
        S_PINIT,
        S_PITCH,
        S_PFIN,
        S_DONE
    } t_state;

    // atan(2^-i) in 1/4096 degree, rounded to nearest.
    function automatic logic signed [ANGLE_W-1:0] atan_step(input logic [ITER_W-1:0] i);
        logic signed [ANGLE_W-1:0] v;
        begin
            case (i)
                5'd0:    v = 22'sd184320;
                5'd1:    v = 22'sd108810;
                5'd2:    v = 22'sd57492;
                5'd3:    v = 22'sd29184;
                5'd4:    v = 22'sd14649;
                5'd5:    v = 22'sd7331;
                5'd6:    v = 22'sd3667;
                5'd7:    v = 22'sd1833;
                5'd8:    v = 22'sd917;
                5'd9:    v = 22'sd458;
                5'd10:   v = 22'sd229;
                5'd11:   v = 22'sd115;
                5'd12:   v = 22'sd57;
                5'd13:   v = 22'sd29;
                5'd14:   v = 22'sd14;
                5'd15:   v = 22'sd7;
                5'd16:   v = 22'sd4;
                5'd17:   v = 22'sd2;
                default: v = 22'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

### hdl/atav_isqrt.sv
module atav_isqrt
    import atav_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_value,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic [RAD_W-1:0] r_rem, n_rem;
    logic [RAD_W-1:0] r_res, n_res;
    logic [RAD_W-1:0] r_bit, n_bit;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [RAD_W-1:0] trial;

    // One root bit per cycle: two radicand bits are retired each step.
    always_comb begin
        trial  = r_res + r_bit;
        n_rem  = r_rem;
        n_res  = r_res;
        n_bit  = r_bit;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = i_value;
            n_res  = '0;
            n_bit  = RAD_W'(1) << (RAD_W - 2);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_rem >= trial) begin
                n_rem = r_rem - trial;
                n_res = (r_res >> 1) + r_bit;
            end else begin
                n_res = r_res >> 1;
            end
            n_bit = r_bit >> 2;
            if (r_bit[0] || r_bit[1]) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_res <= n_res;
        r_bit <= n_bit;
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

### hdl/accel_tilt_angle_averager_top.sv
// Channel  | Direction | Signals                                   | Beat
// ---------+-----------+-------------------------------------------+--------------------------
// sample   | in        | i_in_valid / o_in_ready                   | accel x, y, z
// result   | out       | o_out_valid / i_out_ready                 | flags, roll, pitch
// config   | in        | i_cfg_we, i_cfg_data                      | shock limit, no handshake
//
// One sample is processed at a time. A sample that does not close a window, or is
// rejected, goes from the check state straight to the done state; one that closes a
// window also runs the two 18-step CORDIC passes and the 30-step square root.
// Reset is synchronous, active low; sums, count and held angles clear to zero.
// A waiting result sits in the output register, so the next sample may be taken
// and processed; it finishes only once the output register is free.
module accel_tilt_angle_averager_top
    import atav_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_accel_x,
    input  logic signed [SAMPLE_W-1:0] i_accel_y,
    input  logic signed [SAMPLE_W-1:0] i_accel_z,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_rejected,
    output logic                       o_updated,
    output logic [14:0]                o_roll_angle,
    output logic signed [13:0]         o_pitch_angle,
    input  logic                       i_cfg_we,
    input  logic [LIMIT_W-1:0]         i_cfg_data
);

    t_state r_state, n_state;

    logic [LIMIT_W-1:0]         r_limit;
    logic signed [SAMPLE_W-1:0] r_x, r_y, r_z;
    logic [COUNT_W-1:0]         r_count;
    logic signed [SUM_W-1:0]    r_sx, r_sy, r_sz;
    logic signed [SUM_W-1:0]    r_fx, r_fy, r_fz;
    logic                       r_rej, r_upd, r_rneg;
    logic signed [CDATA_W-1:0]  r_cx, r_cy, n_cx, n_cy;
    logic signed [ANGLE_W-1:0]  r_cz, n_cz;
    logic [ITER_W-1:0]          r_iter;
    logic [SQ_W-1:0]            r_sq;
    logic [14:0]                r_roll;
    logic signed [13:0]         r_pitch;
    logic                       r_ov, r_orej, r_oupd;
    logic [14:0]                r_oroll;
    logic signed [13:0]         r_opitch;

    logic                       in_acc, out_free, last_iter, win_end;
    logic                       sq_start, sq_done;
    logic [ROOT_W-1:0]          sq_root;
    logic [16:0]                mx, my, mz;
    logic                       rej;
    logic signed [SUM_W-1:0]    ax, ay, az;
    logic [MAG_W-1:0]           mag_y, mag_z, mul_op;
    logic [2*MAG_W-1:0]         product;
    logic signed [CDATA_W-1:0]  sy_s, sz_s, dx, dy;
    logic signed [ANGLE_W-1:0]  ra, pa, pmag;
    logic [14:0]                roll_val;
    logic signed [13:0]         pitch_val;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_ov || i_out_ready;
    assign last_iter = (r_iter == ITER_W'(CORDIC_STEPS - 1));

    // Shock check against the limit on the registered sample.
    assign mx  = r_x[SAMPLE_W-1] ? 17'(-$signed({r_x[SAMPLE_W-1], r_x})) : 17'(r_x);
    assign my  = r_y[SAMPLE_W-1] ? 17'(-$signed({r_y[SAMPLE_W-1], r_y})) : 17'(r_y);
    assign mz  = r_z[SAMPLE_W-1] ? 17'(-$signed({r_z[SAMPLE_W-1], r_z})) : 17'(r_z);
    assign rej = (mx > 17'(r_limit)) || (my > 17'(r_limit)) || (mz > 17'(r_limit));

    // Running sums including the current sample.
    assign ax = r_sx + SUM_W'(r_x);
    assign ay = r_sy + SUM_W'(r_y);
    assign az = r_sz + SUM_W'(r_z);
    assign win_end = (7'({1'b0, r_count}) + 7'd1) >= 7'(WINDOW);

    // Shared squaring multiplier for the pitch radius.
    assign mag_y   = r_fy[SUM_W-1] ? MAG_W'(-r_fy) : MAG_W'(r_fy);
    assign mag_z   = r_fz[SUM_W-1] ? MAG_W'(-r_fz) : MAG_W'(r_fz);
    assign mul_op  = (r_state == S_MULY) ? mag_y : mag_z;
    assign product = mul_op * mul_op;

    assign sq_start = (r_state == S_SQST);

    atav_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value ({r_sq[SQ_W-1:0], 16'd0}),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // One CORDIC vectoring rotation per cycle.
    assign dx = r_cy >>> r_iter;
    assign dy = r_cx >>> r_iter;
    assign sy_s = CDATA_W'(r_fy) <<< OP_SHIFT;
    assign sz_s = CDATA_W'(r_fz) <<< OP_SHIFT;

    always_comb begin
        n_cx = r_cx;
        n_cy = r_cy;
        n_cz = r_cz;
        if (r_state == S_RINIT) begin
            n_cx = r_rneg ? -sz_s : sz_s;
            n_cy = r_rneg ? -sy_s : sy_s;
            n_cz = '0;
        end else if (r_state == S_PINIT) begin
            n_cx = CDATA_W'(sq_root);
            n_cy = CDATA_W'(r_fx) <<< OP_SHIFT;
            n_cz = '0;
        end else if (r_state == S_ROLL || r_state == S_PITCH) begin
            if (!r_cy[CDATA_W-1]) begin
                n_cx = r_cx + dx;
                n_cy = r_cy - dy;
                n_cz = r_cz + atan_step(r_iter);
            end else begin
                n_cx = r_cx - dx;
                n_cy = r_cy + dy;
                n_cz = r_cz - atan_step(r_iter);
            end
        end
    end

    // Roll: fold into [0, 360), round to 1/64 degree, clamp; a zero y sum gives 0 or 180.
    always_comb begin
        ra = r_cz + (r_rneg ? DEG180 : '0);
        if (ra < 0) begin
            ra = ra + DEG360;
        end
        if (ra < 0) begin
            ra = '0;
        end
        ra = (ra + 22'sd32) >>> 6;
        if (r_fy == '0) begin
            roll_val = r_fz[SUM_W-1] ? ROLL_HALF : 15'd0;
        end else if (ra > $signed(ANGLE_W'(ROLL_MAX))) begin
            roll_val = ROLL_MAX;
        end else begin
            roll_val = ra[14:0];
        end
    end

    // Pitch: round the magnitude half away from zero, clamp, restore sign; a zero x sum gives 0.
    always_comb begin
        pa   = r_cz[ANGLE_W-1] ? -r_cz : r_cz;
        pmag = (pa + 22'sd32) >>> 6;
        if (pmag > $signed(ANGLE_W'(PITCH_MAX))) begin
            pmag = ANGLE_W'(PITCH_MAX);
        end
        if (r_fx == '0) begin
            pitch_val = '0;
        end else if (r_cz[ANGLE_W-1]) begin
            pitch_val = -$signed(pmag[13:0]);
        end else begin
            pitch_val = pmag[13:0];
        end
    end

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_CHECK;
            S_CHECK: n_state = (!rej && win_end) ? S_RINIT : S_DONE;
            S_RINIT: n_state = S_ROLL;
            S_ROLL:  if (last_iter) n_state = S_MULY;
            S_MULY:  n_state = S_MULZ;
            S_MULZ:  n_state = S_SQST;
            S_SQST:  n_state = S_SQRT;
            S_SQRT:  if (sq_done) n_state = S_PINIT;
            S_PINIT: n_state = S_PITCH;
            S_PITCH: if (last_iter) n_state = S_PFIN;
            S_PFIN:  n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control and held state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= SHOCK_RESET;
            r_count <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_sz    <= '0;
            r_roll  <= '0;
            r_pitch <= '0;
            r_ov    <= 1'b0;
            r_iter  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (r_state == S_CHECK && !rej) begin
                if (win_end) begin
                    r_count <= '0;
                    r_sx    <= '0;
                    r_sy    <= '0;
                    r_sz    <= '0;
                end else begin
                    r_count <= r_count + COUNT_W'(1);
                    r_sx    <= ax;
                    r_sy    <= ay;
                    r_sz    <= az;
                end
            end
            if (r_state == S_ROLL || r_state == S_PITCH) begin
                r_iter <= last_iter ? '0 : r_iter + ITER_W'(1);
            end else begin
                r_iter <= '0;
            end
            if (r_state == S_MULY) begin
                r_roll <= roll_val;
            end
            if (r_state == S_PFIN) begin
                r_pitch <= pitch_val;
            end
            if (r_state == S_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x <= i_accel_x;
            r_y <= i_accel_y;
            r_z <= i_accel_z;
        end
        if (r_state == S_CHECK) begin
            r_rej  <= rej;
            r_upd  <= !rej && win_end;
            r_fx   <= ax;
            r_fy   <= ay;
            r_fz   <= az;
            r_rneg <= az[SUM_W-1];
        end
        r_cx <= n_cx;
        r_cy <= n_cy;
        r_cz <= n_cz;
        if (r_state == S_MULY) begin
            r_sq <= SQ_W'(product);
        end else if (r_state == S_MULZ) begin
            r_sq <= r_sq + SQ_W'(product);
        end
        if (r_state == S_DONE && out_free) begin
            r_orej   <= r_rej;
            r_oupd   <= r_upd;
            r_oroll  <= (r_state == S_DONE) ? r_roll : r_oroll;
            r_opitch <= r_pitch;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_rejected    = r_orej;
    assign o_updated     = r_oupd;
    assign o_roll_angle  = r_oroll;
    assign o_pitch_angle = r_opitch;

    // Checks on the datapath and sequencing.
    a_upd_not_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_updated && o_rejected))
        else $error("result both updated and rejected");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_roll_angle <= ROLL_MAX))
        else $error("roll out of range");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pitch_angle <= $signed(PITCH_MAX))
            && (o_pitch_angle >= -$signed(PITCH_MAX)))
        else $error("pitch out of range");

    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CHECK))
        else $error("accepted sample not checked");

endmodule

### bench/tb_top.sv
module tb_top;
    import atav_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN          = 10;
    localparam int WATCH_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 200;

    localparam int ATAN_TAB [CORDIC_STEPS] = '{
        184320, 108810, 57492, 29184, 14649, 7331, 3667, 1833, 917,
        458, 229, 115, 57, 29, 14, 7, 4, 2
    };

    typedef struct packed {
        logic        rejected;
        logic        updated;
        logic [14:0] roll;
        logic [13:0] pitch;
    } t_angles;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_accel_x;
    logic signed [SAMPLE_W-1:0] i_accel_y;
    logic signed [SAMPLE_W-1:0] i_accel_z;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic                       o_rejected;
    logic                       o_updated;
    logic [14:0]                o_roll_angle;
    logic signed [13:0]         o_pitch_angle;
    logic                       i_cfg_we;
    logic [LIMIT_W-1:0]         i_cfg_data;

    // Predictor state.
    int unsigned limit_mirror;
    int          window_count;
    longint      acc_x, acc_y, acc_z;
    int          roll_hold, pitch_hold;

    t_angles angle_queue[$];
    int      error_count;
    int      idle_cycles;
    bit      idle_enable;

    accel_tilt_angle_averager_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_accel_x     (i_accel_x),
        .i_accel_y     (i_accel_y),
        .i_accel_z     (i_accel_z),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_rejected    (o_rejected),
        .o_updated     (o_updated),
        .o_roll_angle  (o_roll_angle),
        .o_pitch_angle (o_pitch_angle),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Arithmetic shift right that floors toward minus infinity.
    function automatic longint shift_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bit_w;
        begin
            res = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > v) bit_w = bit_w >> 2;
            while (bit_w != 0) begin
                if (v >= res + bit_w) begin
                    v = v - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end else begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
            return longint'(res);
        end
    endfunction

    // Vectoring CORDIC, angle of (x, y) for x >= 0 in 1/4096 degree.
    function automatic longint vector_angle(longint y, longint x);
        longint z, dx, dy;
        begin
            z = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = shift_floor(y, i);
                dy = shift_floor(x, i);
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_TAB[i];
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_TAB[i];
                end
            end
            return z;
        end
    endfunction

    function automatic int roll_of(longint sy, longint sz);
        longint a, r;
        begin
            if (sy == 0) return (sz >= 0) ? 0 : 11520;
            if (sz >= 0) a = vector_angle(sy * 256, sz * 256);
            else a = vector_angle(-sy * 256, -sz * 256) + 180 * 4096;
            if (a < 0) a = a + 360 * 4096;
            if (a < 0) a = 0;
            r = (a + 32) >>> 6;
            if (r > 23040) r = 23040;
            return int'(r);
        end
    endfunction

    function automatic int pitch_of(longint sx, longint sy, longint sz);
        longint ay, az, r, a, mag;
        begin
            if (sx == 0) return 0;
            ay = (sy < 0) ? -sy : sy;
            az = (sz < 0) ? -sz : sz;
            r = int_sqrt((ay * ay + az * az) << 16);
            a = vector_angle(sx * 256, r);
            mag = (((a < 0) ? -a : a) + 32) >>> 6;
            if (mag > 5760) mag = 5760;
            return int'((a < 0) ? -mag : mag);
        end
    endfunction

    // Works out the result beat for one sample and updates the mirror state.
    function automatic t_angles predict_angles(int x, int y, int z);
        t_angles res;
        longint lim;
        begin
            lim = limit_mirror;
            res.rejected = (x > lim || x < -lim || y > lim || y < -lim ||
                            z > lim || z < -lim);
            res.updated = 1'b0;
            if (!res.rejected) begin
                acc_x += x;
                acc_y += y;
                acc_z += z;
                if (window_count + 1 >= WIN) begin
                    roll_hold = roll_of(acc_y, acc_z);
                    pitch_hold = pitch_of(acc_x, acc_y, acc_z);
                    acc_x = 0;
                    acc_y = 0;
                    acc_z = 0;
                    window_count = 0;
                    res.updated = 1'b1;
                end else begin
                    window_count++;
                end
            end
            res.roll = roll_hold[14:0];
            res.pitch = pitch_hold[13:0];
            return res;
        end
    endfunction

    // Sends one sample beat, with an optional random gap before it.
    // Valid stays high after acceptance so that a following beat can take the
    // same edge; it is dropped only for a gap or when the sender pauses.
    task automatic send_sample(int x, int y, int z);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        angle_queue.push_back(predict_angles(x, y, z));
        i_accel_x  <= x[15:0];
        i_accel_y  <= y[15:0];
        i_accel_z  <= z[15:0];
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (angle_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(int unsigned v);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v[14:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        limit_mirror = v & 32'h7FFF;
        @(posedge i_clk);
    endtask

    // Random axis value within the limit, anywhere in the 16-bit range, at the limit, or just past it.
    function automatic int rand_axis(int unsigned lim);
        int unsigned sel;
        begin
            sel = $urandom_range(0, 9);
            if (sel < 7) return $urandom_range(0, 2 * lim) - int'(lim);
            if (sel == 7) return $urandom_range(0, 65535) - 32768;
            if (sel == 8) return $urandom_range(0, 1) ? int'(lim) : -int'(lim);
            return $urandom_range(0, 1) ? int'(lim) + 1 : -int'(lim) - 1;
        end
    endfunction

    task automatic test_reset_limit();
        send_sample(1000, -1000, 0);
        send_sample(1001, 0, 0);
        send_sample(0, -1001, 0);
        send_sample(0, 0, 1001);
        send_sample(-32768, 0, 0);
        repeat (8) send_sample(0, 0, 0);
        send_sample(0, 0, 0);
    endtask

    task automatic test_special_angles();
        write_limit(32767);
        // Negative z with zero y gives half a turn; zero x gives flat pitch.
        repeat (WIN) send_sample(0, 0, -500);
        repeat (WIN) send_sample(32767, 32767, 32767);
        repeat (WIN) send_sample(-32767, -1, 32767);
        send_sample(32767, -32768, 0);
    endtask

    task automatic test_limit_zero();
        write_limit(0);
        send_sample(1, 0, 0);
        repeat (WIN) send_sample(0, 0, 0);
    endtask

    task automatic test_random(int n, int unsigned lim);
        write_limit(lim);
        for (int i = 0; i < n; i++)
            send_sample(rand_axis(lim), rand_axis(lim), rand_axis(lim));
    endtask

    // Checks each result beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_angles exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (angle_queue.size() == 0) begin
                $display("%0t: unexpected result beat", $time);
                error_count++;
            end else begin
                exp_r = angle_queue.pop_front();
                if (o_rejected !== exp_r.rejected) begin
                    $display("%0t: rejected exp %0d got %0d", $time,
                             exp_r.rejected, o_rejected);
                    error_count++;
                end
                if (o_updated !== exp_r.updated) begin
                    $display("%0t: updated exp %0d got %0d", $time,
                             exp_r.updated, o_updated);
                    error_count++;
                end
                if (o_roll_angle !== exp_r.roll) begin
                    $display("%0t: roll exp %0d got %0d", $time,
                             exp_r.roll, o_roll_angle);
                    error_count++;
                end
                if (o_pitch_angle !== $signed(exp_r.pitch)) begin
                    $display("%0t: pitch exp %0d got %0d", $time,
                             $signed(exp_r.pitch), o_pitch_angle);
                    error_count++;
                end
            end
        end
    end

    // Receiver stalls in random bursts while idling is enabled.
    always @(posedge i_clk) begin
        if (!idle_enable) begin
            i_out_ready <= 1'b1;
        end else if (idle_cycles > 0) begin
            idle_cycles <= idle_cycles - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            idle_cycles <= $urandom_range(1, 10) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no accepted beat.
    always @(posedge i_clk) begin
        int quiet;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
        else quiet++;
        if (quiet >= WATCH_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_accel_x   = '0;
        i_accel_y   = '0;
        i_accel_z   = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        idle_enable = 1'b1;
        idle_cycles = 0;
        error_count = 0;
        limit_mirror = 1000;
        window_count = 0;
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        roll_hold = 0;
        pitch_hold = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_limit();
        test_special_angles();
        test_limit_zero();
        test_random(150, 32767);
        test_random(150, 1000);
        test_random(100, $urandom_range(1, 32766));
        test_random(50, 3);
        idle_enable = 1'b0;
        test_random(150, 20000);

        wait_drained();
        if (error_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
